// ===== sv/rbd2x2_pkg.sv =====
// ---------------------------------------------------------------------------
// rbd2x2_pkg
// shared types, constants and channel arithmetic for the 2x2 rgba downscaler
// ---------------------------------------------------------------------------
package rbd2x2_pkg;

  localparam int PIX_W = 32;          // rgba8 pixel
  localparam int CH_W  = 8;           // one channel
  localparam int NCH   = 4;           // r, g, b, a
  localparam int SUM_W = CH_W + 1;    // sum of two channels
  localparam int PS_W  = NCH * SUM_W; // packed pair sums
  localparam int CFG_W = 13;          // register data width
  localparam int ROW_W = CFG_W;       // source row counter

  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [PS_W-1:0]  pair_sum_t;

  // per-channel sum of two pixels, 9-bit lanes
  function automatic pair_sum_t pair_sum(input pixel_t a, input pixel_t b);
    pair_sum_t r;
    r = '0;
    for (int c = 0; c < NCH; c++) begin
      r[c*SUM_W +: SUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
    end
    return r;
  endfunction

  // per-channel (p + q) / 4, truncated
  function automatic pixel_t average(input pair_sum_t p, input pair_sum_t q);
    pixel_t            r;
    logic [SUM_W:0]    s;
    r = '0;
    for (int c = 0; c < NCH; c++) begin
      s = {1'b0, p[c*SUM_W +: SUM_W]} + {1'b0, q[c*SUM_W +: SUM_W]};
      r[c*CH_W +: CH_W] = s[SUM_W:2];
    end
    return r;
  endfunction

endpackage

// ===== sv/rbd2x2_ram.sv =====
// ---------------------------------------------------------------------------
// rbd2x2_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module rbd2x2_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rgba_box_downscale_2x2.sv =====
// ---------------------------------------------------------------------------
// rgba_box_downscale_2x2
// streaming 2x2 box filter, rgba8 source image to its next mip level
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ------------------------------------
//  in_      in   in_tvalid/in_tready  in_tdata: source pixel, raster order
//  out_     out  out_tvalid/tready    out_tdata: averaged pixel, out_tlast
//  cfg_     in   cfg_wr_en            cfg_addr: register, cfg_wdata: value
//
//  one source pixel per clock sustained while the output is not stalled;
//  the transaction that completes a block loads the middle stage (line
//  store read); out_tvalid rises as the output register takes the result.
//  the line store is a single ram with one write and one registered read
//  port; an even row writes pair sums, the odd row below reads them back,
//  at least one source pixel later, so no forwarding is needed. synchronous
//  active-low reset clears the counters and the held pixel; the line store
//  is not cleared. a stalled output holds the pipe: transactions keep
//  flowing until one that completes a block reaches the middle stage, then
//  in_tready drops until out_tready returns.
//
module rgba_box_downscale_2x2
  import rbd2x2_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // [31:0] pixel_in
  // output stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // [31:0] pixel_out
  output logic             out_tlast,  // frame_last
  // configuration
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // line store geometry
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // column counter holds 0 .. MAX_WIDTH-1
  localparam int CXW   = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) : 1;
  // effective width holds 1 .. MAX_WIDTH, compared against the raw register
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

  // configuration registers
  logic [CFG_W-1:0] src_w_r, src_w_nxt;
  logic [CFG_W-1:0] src_h_r, src_h_nxt;

  // stream state
  logic [CXW-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pixel_t           held_r, held_nxt;

  // middle stage: line store read in flight
  logic             s1_valid_r, s1_valid_nxt;
  pair_sum_t        s1_ps_r, s1_ps_nxt;
  logic             s1_self_r, s1_self_nxt;   // single-row image, pair with itself
  logic             s1_last_r, s1_last_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  pixel_t           out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  // effective sizes
  logic [EW-1:0]    w_raw;
  logic [EW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             w_one, h_one;

  // per-transaction decode
  logic             in_acc;
  logic             out_move, s1_move;
  logic             pair_done, do_wr, do_rd, do_emit;
  logic             last_x, last_y;
  pair_sum_t        ps;
  logic [AW-1:0]    x_addr;
  logic [EW-1:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic [EW-1:0]    dst_w_m1;
  logic [ROW_W-1:0] dst_h_m1;
  pair_sum_t        ram_rd_data;
  pair_sum_t        other_ps;

  // zero acts as one, width clamps at the line store size
  always_comb begin
    w_raw = EW'(src_w_r);
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > MAX_W_E) begin
      w_eff = MAX_W_E;
    end else begin
      w_eff = w_raw;
    end
    h_eff = (src_h_r == '0) ? ROW_W'(1) : src_h_r;
    w_one = (w_eff == EW'(1));
    h_one = (h_eff == ROW_W'(1));
  end

  // handshake: output register frees the middle stage, which frees the input
  assign out_move  = !out_valid_r || out_tready;
  assign s1_move   = !s1_valid_r || out_move;
  assign in_tready = s1_move;
  assign in_acc    = in_tvalid && s1_move;

  // block geometry of the current pixel
  always_comb begin
    pair_done = w_one || col_r[0];
    ps        = w_one ? pair_sum(in_tdata, in_tdata) : pair_sum(held_r, in_tdata);
    x_addr    = AW'(col_r >> 1);
    col_inc   = EW'(col_r) + EW'(1);
    row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
    // even row stores unless it is an odd trailing row; odd row reads back
    do_wr     = in_acc && pair_done && !h_one && !row_r[0] &&
                (row_inc < {1'b0, h_eff});
    do_rd     = in_acc && pair_done && !h_one && row_r[0];
    do_emit   = pair_done && (h_one || row_r[0]);
    // last destination pixel of the frame
    dst_w_m1  = (w_eff >> 1) - EW'(1);
    dst_h_m1  = (h_eff >> 1) - ROW_W'(1);
    last_x    = w_one || (EW'(col_r >> 1) == dst_w_m1);
    last_y    = h_one || ((row_r >> 1) == dst_h_m1);
  end

  // line store of even-row pair sums
  rbd2x2_ram #(
    .WIDTH (PS_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (do_wr),
    .wr_addr (x_addr),
    .wr_data (ps),
    .rd_en   (do_rd),
    .rd_addr (x_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    src_w_nxt     = src_w_r;
    src_h_nxt     = src_h_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    held_nxt      = held_r;
    s1_valid_nxt  = s1_valid_r;
    s1_ps_nxt     = s1_ps_r;
    s1_self_nxt   = s1_self_r;
    s1_last_nxt   = s1_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    other_ps      = s1_self_r ? s1_ps_r : ram_rd_data;

    // raster walk, wrap at the end of each row and frame
    if (in_acc) begin
      if (!w_one && !col_r[0]) begin
        held_nxt = in_tdata;
      end
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        if (row_inc >= {1'b0, h_eff}) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[CXW-1:0];
      end
    end

    // a register write restarts the frame
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SOURCE_WIDTH:  src_w_nxt = cfg_wdata;
        REG_SOURCE_HEIGHT: src_h_nxt = cfg_wdata;
        default:           src_w_nxt = src_w_r;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end

    if (s1_move) begin
      s1_valid_nxt = in_acc && do_emit;
      s1_ps_nxt    = ps;
      s1_self_nxt  = h_one;
      s1_last_nxt  = last_x && last_y;
    end

    if (out_move) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = average(other_ps, s1_ps_r);
      out_last_nxt  = s1_last_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= CFG_W'(1);
      src_h_r     <= CFG_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      held_r      <= held_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_ps_r    <= s1_ps_nxt;
    s1_self_r  <= s1_self_nxt;
    s1_last_r  <= s1_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
